// ----- design/rgb_upscale_2x_midpoint_top_macros.svh -----
// ----------------------------------------------------------------------------
// rgb upscaler assertion macros
// immediate-style wrappers for concurrent checks, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef RGB_UPSCALE_2X_MIDPOINT_TOP_MACROS_SVH
`define RGB_UPSCALE_2X_MIDPOINT_TOP_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold in the same cycle
`define RU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define RU_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`else

`define RU_ASSERT(lbl, prop, msg)
`define RU_ASSERT_NEXT(lbl, trig, cons, msg)

`endif

`endif

// ----- design/rgb_up2x_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_up2x_pkg
// shared constants for the 2x midpoint upscaler
// ----------------------------------------------------------------------------
package rgb_up2x_pkg;

    localparam int COORD_W   = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    // result slots of one source pixel, in emission order
    localparam int SLOT_DIAG  = 0;
    localparam int SLOT_ABOVE = 1;
    localparam int SLOT_LEFT  = 2;
    localparam int SLOT_SELF  = 3;
    localparam int SLOTS      = 4;

    typedef logic [SLOTS-1:0] slot_mask_t;

endpackage

// ----- design/rgb_up2x_pix_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_up2x_pix_if
// source pixel channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface rgb_up2x_pix_if #(
    parameter int CHANNEL_BITS = 8
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] pixel_red;
    logic [CHANNEL_BITS-1:0] pixel_green;
    logic [CHANNEL_BITS-1:0] pixel_blue;

    modport source (output valid, output pixel_red, output pixel_green,
                    output pixel_blue, input ready);
    modport sink (input valid, input pixel_red, input pixel_green,
                  input pixel_blue, output ready);
endinterface

// ----- design/rgb_up2x_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_up2x_out_if
// upscaled pixel channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface rgb_up2x_out_if #(
    parameter int CHANNEL_BITS = 8
);
    import rgb_up2x_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [COORD_W-1:0]      out_col;
    logic [COORD_W-1:0]      out_row;
    logic [CHANNEL_BITS-1:0] out_red;
    logic [CHANNEL_BITS-1:0] out_green;
    logic [CHANNEL_BITS-1:0] out_blue;
    logic                    run_last;
    logic                    image_done;

    modport source (output valid, output out_col, output out_row, output out_red,
                    output out_green, output out_blue, output run_last,
                    output image_done, input ready);
    modport sink (input valid, input out_col, input out_row, input out_red,
                  input out_green, input out_blue, input run_last,
                  input image_done, output ready);
endinterface

// ----- design/rgb_upscale_2x_midpoint_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_upscale_2x_midpoint_top
// streaming 2x upscaler, source pixels on even coordinates, midpoints between
// ----------------------------------------------------------------------------
//  channel     dir  beat
//  src_pixel   in   one source rgb pixel, raster order
//  up_pixel    out  one upscaled pixel with its coordinates
//  cfg_*       in   register write, image_width / image_height
//
//  a pixel gives 1, 2 or 4 result beats on up_pixel
//  row memory: read at accept, write as the pixel leaves the read stage, forwarded
//  after accept, a pixel passes the read stage, the expand stage and the output register
//  a register write restarts the image at source pixel (0,0)
//  no clearing pass after reset; stalls on up_pixel back up into src_pixel
// ----------------------------------------------------------------------------
`include "rgb_upscale_2x_midpoint_top_macros.svh"

module rgb_upscale_2x_midpoint_top #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_HEIGHT   = 2048,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    rgb_up2x_pix_if.sink                        src_pixel,
    rgb_up2x_out_if.source                      up_pixel,
    input  logic                                cfg_wr_en,
    input  logic [rgb_up2x_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgb_up2x_pkg::CFG_W-1:0]      cfg_data
);
    import rgb_up2x_pkg::*;

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CB = CHANNEL_BITS;
    localparam int PW = 3 * CB;

    typedef logic [PW-1:0] pix_t;

    function automatic int unsigned last_index(input logic [CFG_W-1:0] v,
                                               input int unsigned maxv);
        int unsigned e;
        begin
            if (v == '0)
                e = 1;
            else if (32'(v) > maxv)
                e = maxv;
            else
                e = 32'(v);
            return e - 1;
        end
    endfunction

    function automatic pix_t avg2(input pix_t a, input pix_t b);
        pix_t o;
        logic [CB:0] s;
        begin
            o = '0;
            for (int c = 0; c < 3; c++)
            begin
                s = {1'b0, a[c*CB +: CB]} + {1'b0, b[c*CB +: CB]};
                o[c*CB +: CB] = s[CB:1];
            end
            return o;
        end
    endfunction

    function automatic pix_t avg4(input pix_t a, input pix_t b, input pix_t c4,
                                  input pix_t d);
        pix_t o;
        logic [CB+1:0] s;
        begin
            o = '0;
            for (int c = 0; c < 3; c++)
            begin
                s = {2'b00, a[c*CB +: CB]} + {2'b00, b[c*CB +: CB]}
                  + {2'b00, c4[c*CB +: CB]} + {2'b00, d[c*CB +: CB]};
                o[c*CB +: CB] = s[CB+1:2];
            end
            return o;
        end
    endfunction

    // configuration and position
    logic [XW-1:0] last_x_reg, last_x_next;
    logic [YW-1:0] last_y_reg, last_y_next;
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;

    // read stage
    logic          s1_valid_reg;
    pix_t          s1_cur_reg;
    logic [XW-1:0] s1_x_reg;
    logic [YW-1:0] s1_y_reg;
    logic          s1_done_reg;
    pix_t          rd_data_reg;
    logic          fwd_reg;
    pix_t          fwd_data_reg;
    pix_t          above;

    pix_t          row_mem [MAX_WIDTH];

    pix_t          left_reg;
    pix_t          above_left_reg;

    // expand stage
    slot_mask_t    exp_mask_reg, exp_mask_next;
    pix_t          exp_pix_reg [SLOTS];
    logic [XW-1:0] exp_x_reg;
    logic [YW-1:0] exp_y_reg;
    logic          exp_done_reg;

    // output register
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic [COORD_W-1:0] out_row_reg;
    pix_t               out_pix_reg;
    logic               out_last_reg;
    logic               out_done_reg;

    logic          in_accept;
    logic          out_load;
    logic          exp_free;
    logic          move;
    slot_mask_t    sel;
    logic [1:0]    sel_idx;
    logic          sel_last;
    logic [XW:0]   col_even;
    logic [XW:0]   col_odd;
    logic [YW:0]   row_even;
    logic [YW:0]   row_odd;

    always_comb
    begin
        sel     = exp_mask_reg & (~exp_mask_reg + slot_mask_t'(1));
        sel_idx = 2'(SLOT_SELF);
        for (int k = SLOTS - 1; k >= 0; k--)
        begin
            if (sel[k])
                sel_idx = 2'(k);
        end
        sel_last = (exp_mask_reg & ~sel) == '0;
        col_even = {exp_x_reg, 1'b0};
        col_odd  = col_even - (XW+1)'(1);
        row_even = {exp_y_reg, 1'b0};
        row_odd  = row_even - (YW+1)'(1);
    end

    assign out_load  = (exp_mask_reg != '0) && (!out_valid_reg || up_pixel.ready);
    assign exp_free  = (exp_mask_reg == '0) || (out_load && sel_last);
    assign move      = s1_valid_reg && exp_free;
    assign in_accept = src_pixel.valid && src_pixel.ready;
    assign above     = fwd_reg ? fwd_data_reg : rd_data_reg;

    assign src_pixel.ready = !s1_valid_reg || move;

    always_comb
    begin
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  last_x_next = XW'(last_index(cfg_data, MAX_WIDTH));
                CFG_IMAGE_HEIGHT: last_y_next = YW'(last_index(cfg_data, MAX_HEIGHT));
                default:          last_x_next = last_x_reg;
            endcase
            x_next = '0;
            y_next = '0;
        end
        else if (in_accept)
        begin
            if (x_reg == last_x_reg)
            begin
                x_next = '0;
                y_next = (y_reg == last_y_reg) ? '0 : y_reg + YW'(1);
            end
            else
            begin
                x_next = x_reg + XW'(1);
            end
        end
    end

    always_comb
    begin
        exp_mask_next = exp_mask_reg;
        if (move)
        begin
            exp_mask_next[SLOT_DIAG]  = (s1_x_reg != '0) && (s1_y_reg != '0);
            exp_mask_next[SLOT_ABOVE] = s1_y_reg != '0;
            exp_mask_next[SLOT_LEFT]  = s1_x_reg != '0;
            exp_mask_next[SLOT_SELF]  = 1'b1;
        end
        else if (out_load)
        begin
            exp_mask_next = exp_mask_reg & ~sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg     <= XW'(last_index(WIDTH_RESET, MAX_WIDTH));
            last_y_reg     <= YW'(last_index(HEIGHT_RESET, MAX_HEIGHT));
            x_reg          <= '0;
            y_reg          <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_reg        <= 1'b0;
            left_reg       <= '0;
            above_left_reg <= '0;
            exp_mask_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            last_x_reg   <= last_x_next;
            last_y_reg   <= last_y_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            exp_mask_reg <= exp_mask_next;
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= move && (s1_x_reg == x_reg);
            end
            else if (move)
            begin
                s1_valid_reg <= 1'b0;
                fwd_reg      <= 1'b0;
            end
            if (move)
            begin
                left_reg       <= s1_cur_reg;
                above_left_reg <= above;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (up_pixel.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // row memory, read-before-write
    always_ff @(posedge clk)
    begin
        if (in_accept)
            rd_data_reg <= row_mem[x_reg];
        if (move)
            row_mem[s1_x_reg] <= s1_cur_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cur_reg   <= {src_pixel.pixel_blue, src_pixel.pixel_green,
                             src_pixel.pixel_red};
            s1_x_reg     <= x_reg;
            s1_y_reg     <= y_reg;
            s1_done_reg  <= (x_reg == last_x_reg) && (y_reg == last_y_reg);
            fwd_data_reg <= s1_cur_reg;
        end
        if (move)
        begin
            exp_pix_reg[SLOT_DIAG]  <= avg4(above_left_reg, above, left_reg, s1_cur_reg);
            exp_pix_reg[SLOT_ABOVE] <= avg2(above, s1_cur_reg);
            exp_pix_reg[SLOT_LEFT]  <= avg2(left_reg, s1_cur_reg);
            exp_pix_reg[SLOT_SELF]  <= s1_cur_reg;
            exp_x_reg               <= s1_x_reg;
            exp_y_reg               <= s1_y_reg;
            exp_done_reg            <= s1_done_reg;
        end
        if (out_load)
        begin
            out_col_reg  <= sel_idx[0] ? COORD_W'(col_even) : COORD_W'(col_odd);
            out_row_reg  <= sel_idx[1] ? COORD_W'(row_even) : COORD_W'(row_odd);
            out_pix_reg  <= exp_pix_reg[sel_idx];
            out_last_reg <= sel_last;
            out_done_reg <= sel_last && exp_done_reg;
        end
    end

    assign up_pixel.valid      = out_valid_reg;
    assign up_pixel.out_col    = out_col_reg;
    assign up_pixel.out_row    = out_row_reg;
    assign up_pixel.out_red    = out_pix_reg[0*CB +: CB];
    assign up_pixel.out_green  = out_pix_reg[1*CB +: CB];
    assign up_pixel.out_blue   = out_pix_reg[2*CB +: CB];
    assign up_pixel.run_last   = out_last_reg;
    assign up_pixel.image_done = out_done_reg;

    `RU_ASSERT(a_self_slot, (exp_mask_reg == '0) || exp_mask_reg[SLOT_SELF], "pending results lack own pixel")
    `RU_ASSERT(a_done_last, !(out_valid_reg && out_done_reg) || out_last_reg, "image end not on last beat of pixel")
    `RU_ASSERT(a_fwd_held, !fwd_reg || s1_valid_reg, "forward flag without pixel in read stage")
    `RU_ASSERT_NEXT(a_accept_fill, in_accept, s1_valid_reg, "accepted pixel missing from read stage")

endmodule
